>>> hdl/hpu_pkg.sv
// ----------------------------------------------------------------------------
// hpu_pkg: shared constants and helpers for the handheld palette unit
// register addresses, item mode codes, grey defaults and address wrap
// ----------------------------------------------------------------------------
package hpu_pkg;

  localparam int unsigned PALETTE_BYTES_DEF = 64;

  // item mode codes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // register addresses (low byte)
  localparam logic [7:0] ADDR_BG_SHADE   = 8'h47;
  localparam logic [7:0] ADDR_OBJ_SHADE0 = 8'h48;
  localparam logic [7:0] ADDR_OBJ_SHADE1 = 8'h49;
  localparam logic [7:0] ADDR_BG_INDEX   = 8'h68;
  localparam logic [7:0] ADDR_BG_DATA    = 8'h69;
  localparam logic [7:0] ADDR_OBJ_INDEX  = 8'h6A;
  localparam logic [7:0] ADDR_OBJ_DATA   = 8'h6B;

  localparam logic [5:0] INDEX_MASK = 6'h3F;

  // grey ramp ffff (7fff once bit 15 drops), 56b5, 294a, 0000 as little-endian bytes
  localparam logic [7:0] GREY_BYTES [8] = '{
    8'hFF, 8'hFF, 8'hB5, 8'h56, 8'h4A, 8'h29, 8'h00, 8'h00
  };

  // 6-bit address modulo n, n between 8 and 64: at most seven subtractions
  function automatic logic [5:0] wrap_addr(input logic [5:0] a, input logic [6:0] n);
    logic [6:0] r;
    r = {1'b0, a};
    for (int i = 0; i < 7; i++) begin
      if (r >= n) begin
        r = r - n;
      end
    end
    return r[5:0];
  endfunction

  // power-up byte: greys in palette 0 (background) or palettes 0 and 1 (objects)
  function automatic logic [7:0] default_byte(input logic is_obj, input logic [5:0] a);
    logic in_greys;
    in_greys = is_obj ? (a < 6'd16) : (a < 6'd8);
    return in_greys ? GREY_BYTES[a[2:0]] : 8'h00;
  endfunction

  // auto increment when bit 7 is set: low six bits wrap, bits 7 and 6 kept; else unchanged
  function automatic logic [7:0] bump_index(input logic [7:0] r);
    logic [5:0] low;
    low = r[5:0] + 6'd1;
    return r[7] ? {r[7:6], low} : r;
  endfunction

endpackage

>>> hdl/handheld_palette_unit_top.sv
// ----------------------------------------------------------------------------
// handheld_palette_unit_top: palette unit of a handheld console
// shade and index registers, two byte-wide palette memories, color lookup
// ----------------------------------------------------------------------------
// a lookup item shows its color on out_* after its palette read and output register;
// a register write item gives no result and takes effect at its accept edge
// one item per cycle while the result side keeps up; the two-read palette
// memory (registered read) feeds the output register, which drives out_*
// reset clears the control, shade and index registers and the per-byte valid
// bits; a palette byte never written reads as its power-up grey or zero value
module handheld_palette_unit_top #(
  parameter int unsigned PALETTE_BYTES = hpu_pkg::PALETTE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  // item input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_write_data,
  input  logic        in_lookup_object,
  input  logic [2:0]  in_palette_number,
  input  logic [1:0]  in_color_number,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] out_color
);

  localparam int unsigned AW = $clog2(PALETTE_BYTES);
  localparam logic [6:0] NBYTES = 7'(PALETTE_BYTES);

  // ---------------- configuration ----------------
  logic color_mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      color_mode_r <= cfg_data;
    end
  end

  // ---------------- handshake ----------------
  logic s1_valid_r;   // palette bytes read, waiting for output register
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;
  logic wr_acc;
  logic lk_acc;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign wr_acc   = in_acc && (in_mode == hpu_pkg::MODE_WRITE);
  assign lk_acc   = in_acc && (in_mode == hpu_pkg::MODE_LOOKUP);

  // ---------------- shade and index registers ----------------
  logic [7:0] bg_shade_r;
  logic [7:0] obj_shade0_r;
  logic [7:0] obj_shade1_r;
  logic [7:0] bg_idx_r;
  logic [7:0] bg_idx_nxt;
  logic [7:0] obj_idx_r;
  logic [7:0] obj_idx_nxt;
  logic       bg_we;
  logic       obj_we;

  assign bg_we  = wr_acc && (in_reg_addr == hpu_pkg::ADDR_BG_DATA);
  assign obj_we = wr_acc && (in_reg_addr == hpu_pkg::ADDR_OBJ_DATA);

  always_comb begin
    bg_idx_nxt  = bg_idx_r;
    obj_idx_nxt = obj_idx_r;
    if (wr_acc) begin
      case (in_reg_addr)
        hpu_pkg::ADDR_BG_INDEX:  bg_idx_nxt  = in_write_data;
        hpu_pkg::ADDR_OBJ_INDEX: obj_idx_nxt = in_write_data;
        hpu_pkg::ADDR_BG_DATA:   bg_idx_nxt  = hpu_pkg::bump_index(bg_idx_r);
        hpu_pkg::ADDR_OBJ_DATA:  obj_idx_nxt = hpu_pkg::bump_index(obj_idx_r);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_shade_r   <= 8'h00;
      obj_shade0_r <= 8'h00;
      obj_shade1_r <= 8'h00;
      bg_idx_r     <= 8'h00;
      obj_idx_r    <= 8'h00;
    end else begin
      bg_idx_r  <= bg_idx_nxt;
      obj_idx_r <= obj_idx_nxt;
      if (wr_acc) begin
        case (in_reg_addr)
          hpu_pkg::ADDR_BG_SHADE:   bg_shade_r   <= in_write_data;
          hpu_pkg::ADDR_OBJ_SHADE0: obj_shade0_r <= in_write_data;
          hpu_pkg::ADDR_OBJ_SHADE1: obj_shade1_r <= in_write_data;
          default: ;
        endcase
      end
    end
  end

  // ---------------- write address ----------------
  logic [5:0]    bg_wa6;
  logic [5:0]    obj_wa6;
  logic [AW-1:0] bg_wa;
  logic [AW-1:0] obj_wa;

  assign bg_wa6  = hpu_pkg::wrap_addr(bg_idx_r[5:0] & hpu_pkg::INDEX_MASK, NBYTES);
  assign obj_wa6 = hpu_pkg::wrap_addr(obj_idx_r[5:0] & hpu_pkg::INDEX_MASK, NBYTES);
  assign bg_wa   = bg_wa6[AW-1:0];
  assign obj_wa  = obj_wa6[AW-1:0];

  // ---------------- lookup address ----------------
  // mono: object layer uses palette bit 0 for both shade and palette,
  // the layer's shade register remaps the color number
  logic [2:0]    pal_eff;
  logic [7:0]    shade;
  logic [1:0]    color_id;
  logic [5:0]    ra0_6;
  logic [5:0]    ra1_6;
  logic [AW-1:0] ra0;
  logic [AW-1:0] ra1;

  always_comb begin
    pal_eff  = in_palette_number;
    shade    = bg_shade_r;
    color_id = in_color_number;
    if (!color_mode_r) begin
      if (in_lookup_object) begin
        pal_eff = {2'b00, in_palette_number[0]};
        shade   = in_palette_number[0] ? obj_shade1_r : obj_shade0_r;
      end
      color_id = shade[{in_color_number, 1'b0} +: 2];
    end
  end

  // low byte at palette*8 + 2*color, high byte right after it
  assign ra0_6 = hpu_pkg::wrap_addr({pal_eff, color_id, 1'b0}, NBYTES);
  assign ra1_6 = hpu_pkg::wrap_addr({pal_eff, color_id, 1'b1}, NBYTES);
  assign ra0   = ra0_6[AW-1:0];
  assign ra1   = ra1_6[AW-1:0];

  // ---------------- palette memories ----------------
  logic [7:0]               bg_mem  [PALETTE_BYTES];
  logic [7:0]               obj_mem [PALETTE_BYTES];
  logic [PALETTE_BYTES-1:0] bg_vld_r;
  logic [PALETTE_BYTES-1:0] obj_vld_r;

  always_ff @(posedge clk) begin
    if (bg_we) begin
      bg_mem[bg_wa] <= in_write_data;
    end
    if (obj_we) begin
      obj_mem[obj_wa] <= in_write_data;
    end
  end

  // written-since-reset marks; unmarked bytes read as their power-up value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_vld_r  <= '0;
      obj_vld_r <= '0;
    end else begin
      if (bg_we) begin
        bg_vld_r[bg_wa] <= 1'b1;
      end
      if (obj_we) begin
        obj_vld_r[obj_wa] <= 1'b1;
      end
    end
  end

  // registered two-address read of the chosen layer
  logic [7:0]    q0_r;
  logic [7:0]    q1_r;
  logic          v0_r;
  logic          v1_r;
  logic [AW-1:0] ra0_r;
  logic [AW-1:0] ra1_r;
  logic          obj_r;

  always_ff @(posedge clk) begin
    if (lk_acc) begin
      q0_r  <= in_lookup_object ? obj_mem[ra0] : bg_mem[ra0];
      q1_r  <= in_lookup_object ? obj_mem[ra1] : bg_mem[ra1];
      v0_r  <= in_lookup_object ? obj_vld_r[ra0] : bg_vld_r[ra0];
      v1_r  <= in_lookup_object ? obj_vld_r[ra1] : bg_vld_r[ra1];
      ra0_r <= ra0;
      ra1_r <= ra1;
      obj_r <= in_lookup_object;
    end
  end

  // ---------------- merge and output register ----------------
  logic [7:0]  lo_byte;
  logic [7:0]  hi_byte;
  logic [14:0] color_r;

  assign lo_byte = v0_r ? q0_r : hpu_pkg::default_byte(obj_r, 6'(ra0_r));
  assign hi_byte = v1_r ? q1_r : hpu_pkg::default_byte(obj_r, 6'(ra1_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (lk_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // bit 7 of the high byte is dropped
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      color_r <= {hi_byte[6:0], lo_byte};
    end
  end

  assign out_valid = out_valid_r;
  assign out_color = color_r;

  // ---------------- assertions ----------------
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("item accepted while both stages are held");

  a_lookup_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    lk_acc |=> s1_valid_r)
    else $error("lookup item lost after memory read");

  a_bg_index_bump: assert property (@(posedge clk) disable iff (!rst_n)
    bg_we && bg_idx_r[7] |=> bg_idx_r[5:0] == $past(bg_idx_r[5:0]) + 6'd1)
    else $error("background index did not advance");

  a_bg_mark_set: assert property (@(posedge clk) disable iff (!rst_n)
    bg_we |=> bg_vld_r[$past(bg_wa)])
    else $error("background byte write not marked");

  a_no_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_acc && !s1_valid_r |=> !s1_valid_r)
    else $error("register write produced a result");

endmodule
